[rtl/request_window_tracker_defines.svh]
// Assertion macros for the request window tracker checker.
// Depends on nothing; included by the checker file.
`ifndef REQUEST_WINDOW_TRACKER_DEFINES_SVH
`define REQUEST_WINDOW_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is active.
`define RWT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("request window tracker check failed");

// Next-cycle implication, sampled on clk, off while reset is active.
`define RWT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("request window tracker check failed");

`endif

[rtl/rwt_pkg.sv]
// Shared types and constants of the request window tracker.
// No dependencies; used by the tracker top level, its checker and the testbench.
package rwt_pkg;

	typedef enum logic [2:0] {
		RT_DOWNLOAD   = 3'd0,
		RT_CANCEL     = 3'd1,
		RT_REJECT     = 3'd2,
		RT_PIECE      = 3'd3,
		RT_CHOKE      = 3'd4,
		RT_TICK       = 3'd5,
		RT_CHECK      = 3'd6,
		RT_CANCEL_ALL = 3'd7
	} req_type_t;

	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_SEND_REQUEST = 3'd1,
		ACT_SEND_CANCEL  = 3'd2,
		ACT_REJECTED     = 3'd3,
		ACT_DOWNLOADED   = 3'd4
	} action_t;

	typedef enum logic [0:0] {
		CFG_FAST_EXT = 1'b0,
		CFG_TIMEOUT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DL,
		ST_Q_RD,
		ST_Q_CHK,
		ST_S_RD,
		ST_S_CHK,
		ST_RF_CALC,
		ST_EMIT1,
		ST_RF_RD,
		ST_RF_WR,
		ST_CK_RD,
		ST_CK_CHK,
		ST_CK_REQ,
		ST_DR_S_RD,
		ST_DR_S_OUT,
		ST_DR_Q_RD,
		ST_DR_Q_OUT,
		ST_FIN
	} state_t;

	localparam logic [31:0] TIMEOUT_RST    = 32'd60000;
	localparam logic [5:0]  WAIT_LIMIT_RST = 6'd25;
	localparam logic [6:0]  WAIT_LIMIT_MIN = 7'd10;

	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] chunk_index;
		logic [31:0] block_offset;
		logic [31:0] block_length;
		logic [31:0] download_rate;
	} in_item_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] out_chunk_index;
		logic [31:0] out_block_offset;
		logic [31:0] out_block_length;
		logic        last;
		logic        can_add;
		logic [4:0]  outstanding_count;
		logic [5:0]  waiting_count;
		logic        dropped;
	} out_item_t;

	typedef struct packed {
		logic [31:0] chunk_index;
		logic [31:0] block_offset;
		logic [31:0] block_length;
	} ent_t;

	typedef struct packed {
		ent_t        e;
		logic [31:0] stamp;
	} sent_ent_t;

endpackage

[rtl/rwt_ram.sv]
// Simple dual-port RAM with a registered, enabled read port.
// No dependencies; holds the FIFO entries of the tracker.
module rwt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/request_window_tracker.sv]
// Request window tracker top level: FSM, counters and the two entry RAMs.
// Depends on rwt_pkg and rwt_ram.
//
// Usage:
//  - req channel (req_valid/req_ready/req) carries one command per transfer:
//    download, cancel, rejected, piece, choke, tick, check timeouts, cancel all.
//  - rsp channel (rsp_valid/rsp_ready/rsp) returns one or more results per
//    command; the final one has last set. A command with no action returns a
//    single result with action none.
//  - cfg_we/cfg_index/cfg_data write the fast-extension enable (index 0) and
//    timeout_ticks (index 1); write only while no command is in flight.
// Timing: one command at a time; req_ready is high only while idle. Each
//  stored entry that a command walks takes a RAM read state, then a check
//  or write-back state, since the entry RAMs have a registered read port.
//  A choke drains up to 48 stored entries (sent, then queued).
// Reset clears counters, heads, tick clock and registers; RAM contents stay
//  undefined and are only read below the counts. A stalled receiver holds the
//  sequencer at its next result; one result waits in the output register and
//  one more in a pending stage, so last can be settled before it is shown.
module request_window_tracker #(
	parameter int SENT_DEPTH     = 16,
	parameter int QUEUE_DEPTH    = 32,
	parameter int PIECE_LEN_LOG2 = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rwt_pkg::in_item_t   req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rwt_pkg::out_item_t  rsp,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int SAW = SENT_DEPTH > 1 ? $clog2(SENT_DEPTH) : 1;
	localparam int SCW = $clog2(SENT_DEPTH + 1);
	localparam int QAW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = (QCW > SCW ? QCW : SCW) + 1;
	localparam int WAIT_CAP = QUEUE_DEPTH < 63 ? QUEUE_DEPTH : 63;
	localparam logic [35:0] RATE_RND = (36'(1) << PIECE_LEN_LOG2) - 36'(1);

	// circular addressing: base + offset, wrapped once at the depth
	function automatic logic [SAW-1:0] s_at(input logic [SAW-1:0] base,
	                                        input logic [SCW-1:0] off);
		logic [SAW+1:0] sum;
		sum = (SAW+2)'(base) + (SAW+2)'(off);
		if (sum >= (SAW+2)'(SENT_DEPTH)) begin
			sum = sum - (SAW+2)'(SENT_DEPTH);
		end
		return sum[SAW-1:0];
	endfunction

	function automatic logic [QAW-1:0] q_at(input logic [QAW-1:0] base,
	                                        input logic [QCW-1:0] off);
		logic [QAW+1:0] sum;
		sum = (QAW+2)'(base) + (QAW+2)'(off);
		if (sum >= (QAW+2)'(QUEUE_DEPTH)) begin
			sum = sum - (QAW+2)'(QUEUE_DEPTH);
		end
		return sum[QAW-1:0];
	endfunction

	rwt_pkg::state_t state_q, state_d;
	rwt_pkg::in_item_t op_q;

	logic            fast_q;
	logic [31:0]     tmo_q;
	logic [31:0]     tick_q, tick_d;
	logic [SAW-1:0]  sh_q, sh_d;
	logic [SCW-1:0]  sc_q, sc_d;
	logic [QAW-1:0]  qh_q, qh_d;
	logic [QCW-1:0]  qc_q, qc_d;
	logic [5:0]      wl_q, wl_d;
	logic [SCW-1:0]  si_q, si_d, sk_q, sk_d;
	logic [QCW-1:0]  qi_q, qi_d, qk_q, qk_d;
	logic            hit_q, hit_d;
	logic [SCW-1:0]  fs_q, fs_d;
	logic [QCW-1:0]  fq_q, fq_d;
	logic [5:0]      flim_q, flim_d;
	logic            drop_q, drop_d;
	logic [SCW-1:0]  w_q, w_d;

	// result staging: pending stage p, output register o
	logic                p_v_q, o_v_q;
	rwt_pkg::out_item_t  p_q, o_q;
	logic                emit_v, fin_move, shift_ok, slot_ok;
	rwt_pkg::action_t    emit_act;
	rwt_pkg::ent_t       emit_e;
	rwt_pkg::out_item_t  emit_item, fin_item;

	// RAM ports
	logic                q_we, q_re, s_we, s_re;
	logic [QAW-1:0]      q_waddr, q_raddr;
	logic [SAW-1:0]      s_waddr, s_raddr;
	rwt_pkg::ent_t       q_wdata, q_rdata;
	rwt_pkg::sent_ent_t  s_wdata, s_rdata;

	logic            acc;
	logic            q_match, s_match, stale;
	logic [35:0]     rate_sum;
	logic [35:0]     rate_ceil;
	logic [CW-1:0]   avail, moves;
	logic [6:0]      lim;

	rwt_ram #(.WIDTH($bits(rwt_pkg::ent_t)), .DEPTH(QUEUE_DEPTH)) u_queued_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	rwt_ram #(.WIDTH($bits(rwt_pkg::sent_ent_t)), .DEPTH(SENT_DEPTH)) u_sent_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign req_ready = (state_q == rwt_pkg::ST_IDLE);
	assign acc       = req_valid & req_ready;
	assign rsp_valid = o_v_q;
	assign rsp       = o_q;

	// output register frees when empty or taken this cycle
	assign shift_ok = !o_v_q || rsp_ready;
	assign slot_ok  = !p_v_q || shift_ok;

	assign q_match = (q_rdata.chunk_index == op_q.chunk_index) &&
	                 (q_rdata.block_offset == op_q.block_offset) &&
	                 (q_rdata.block_length == op_q.block_length);
	assign s_match = (s_rdata.e.chunk_index == op_q.chunk_index) &&
	                 (s_rdata.e.block_offset == op_q.block_offset) &&
	                 (s_rdata.e.block_length == op_q.block_length);
	// age wraps with the tick clock
	assign stale   = (tick_q - s_rdata.stamp) > tmo_q;

	// window = 1 + ceil(10 * rate / piece length), saturated to the sent depth
	assign rate_sum  = (36'(req.download_rate) << 3) + (36'(req.download_rate) << 1) + RATE_RND;
	assign rate_ceil = rate_sum >> PIECE_LEN_LOG2;

	// refill budget and the new wait limit, from the registered window
	always_comb begin
		avail = (CW'(w_q) > CW'(sc_q)) ? CW'(w_q) - CW'(sc_q) : '0;
		moves = (CW'(qc_q) < avail) ? CW'(qc_q) : avail;
		lim   = 7'(w_q) << 1;
		if (lim < rwt_pkg::WAIT_LIMIT_MIN) begin
			lim = rwt_pkg::WAIT_LIMIT_MIN;
		end
		if (lim > 7'(WAIT_CAP)) begin
			lim = 7'(WAIT_CAP);
		end
	end

	always_comb begin
		state_d  = state_q;
		tick_d   = tick_q;
		sh_d     = sh_q;
		sc_d     = sc_q;
		qh_d     = qh_q;
		qc_d     = qc_q;
		wl_d     = wl_q;
		si_d     = si_q;
		sk_d     = sk_q;
		qi_d     = qi_q;
		qk_d     = qk_q;
		hit_d    = hit_q;
		fs_d     = fs_q;
		fq_d     = fq_q;
		flim_d   = flim_q;
		drop_d   = drop_q;
		w_d      = w_q;
		emit_v   = 1'b0;
		emit_act = rwt_pkg::ACT_NONE;
		emit_e   = '0;
		fin_move = 1'b0;
		q_we     = 1'b0;
		q_waddr  = '0;
		q_wdata  = q_rdata;
		q_re     = 1'b0;
		q_raddr  = '0;
		s_we     = 1'b0;
		s_waddr  = '0;
		s_wdata  = s_rdata;
		s_re     = 1'b0;
		s_raddr  = '0;

		case (state_q)
			rwt_pkg::ST_IDLE: begin
				if (req_valid) begin
					w_d    = (rate_ceil >= 36'(SENT_DEPTH)) ? SCW'(SENT_DEPTH)
					                                        : SCW'(rate_ceil + 36'd1);
					drop_d = 1'b0;
					hit_d  = 1'b0;
					si_d   = '0;
					sk_d   = '0;
					qi_d   = '0;
					qk_d   = '0;
					fs_d   = sc_q;
					fq_d   = qc_q;
					flim_d = wl_q;
					case (req.req_type)
						rwt_pkg::RT_DOWNLOAD: state_d = rwt_pkg::ST_DL;
						rwt_pkg::RT_CANCEL:   state_d = rwt_pkg::ST_Q_RD;
						rwt_pkg::RT_PIECE:    state_d = rwt_pkg::ST_Q_RD;
						rwt_pkg::RT_REJECT:   state_d = rwt_pkg::ST_S_RD;
						rwt_pkg::RT_CHOKE: begin
							if (fast_q) begin
								state_d = rwt_pkg::ST_FIN;
							end else begin
								fs_d    = '0;
								fq_d    = '0;
								state_d = rwt_pkg::ST_DR_S_RD;
							end
						end
						rwt_pkg::RT_TICK: begin
							tick_d  = tick_q + 32'd1;
							state_d = rwt_pkg::ST_FIN;
						end
						rwt_pkg::RT_CHECK: state_d = rwt_pkg::ST_CK_RD;
						rwt_pkg::RT_CANCEL_ALL: begin
							fs_d    = '0;
							fq_d    = '0;
							state_d = rwt_pkg::ST_DR_S_RD;
						end
						default: state_d = rwt_pkg::ST_FIN;
					endcase
				end
			end

			// append to the queued tail, or flag the drop
			rwt_pkg::ST_DL: begin
				if (qc_q >= QCW'(QUEUE_DEPTH)) begin
					drop_d = 1'b1;
				end else begin
					q_we    = 1'b1;
					q_waddr = q_at(qh_q, qc_q);
					q_wdata.chunk_index  = op_q.chunk_index;
					q_wdata.block_offset = op_q.block_offset;
					q_wdata.block_length = op_q.block_length;
					qc_d = qc_q + QCW'(1);
				end
				state_d = rwt_pkg::ST_RF_CALC;
			end

			// compact the queued FIFO, dropping matches
			rwt_pkg::ST_Q_RD: begin
				if (qi_q < qc_q) begin
					q_re    = 1'b1;
					q_raddr = q_at(qh_q, qi_q);
					state_d = rwt_pkg::ST_Q_CHK;
				end else begin
					qc_d = qk_q;
					fq_d = qk_q;
					if (hit_q) begin
						state_d = (op_q.req_type == rwt_pkg::RT_PIECE) ? rwt_pkg::ST_RF_CALC
						                                               : rwt_pkg::ST_FIN;
					end else begin
						si_d    = '0;
						sk_d    = '0;
						state_d = rwt_pkg::ST_S_RD;
					end
				end
			end

			rwt_pkg::ST_Q_CHK: begin
				if (q_match) begin
					hit_d = 1'b1;
				end else begin
					q_we    = 1'b1;
					q_waddr = q_at(qh_q, qk_q);
					q_wdata = q_rdata;
					qk_d    = qk_q + QCW'(1);
				end
				qi_d    = qi_q + QCW'(1);
				state_d = rwt_pkg::ST_Q_RD;
			end

			// compact the sent FIFO, dropping matches
			rwt_pkg::ST_S_RD: begin
				if (si_q < sc_q) begin
					s_re    = 1'b1;
					s_raddr = s_at(sh_q, si_q);
					state_d = rwt_pkg::ST_S_CHK;
				end else begin
					sc_d = sk_q;
					fs_d = sk_q;
					if (op_q.req_type == rwt_pkg::RT_PIECE) begin
						state_d = rwt_pkg::ST_RF_CALC;
					end else if (hit_q) begin
						state_d = rwt_pkg::ST_EMIT1;
					end else begin
						state_d = rwt_pkg::ST_FIN;
					end
				end
			end

			rwt_pkg::ST_S_CHK: begin
				if (s_match) begin
					hit_d = 1'b1;
				end else begin
					s_we    = 1'b1;
					s_waddr = s_at(sh_q, sk_q);
					s_wdata = s_rdata;
					sk_d    = sk_q + SCW'(1);
				end
				si_d    = si_q + SCW'(1);
				state_d = rwt_pkg::ST_S_RD;
			end

			// settle final counts and wait limit before any refill result
			rwt_pkg::ST_RF_CALC: begin
				fs_d    = SCW'(CW'(sc_q) + moves);
				fq_d    = QCW'(CW'(qc_q) - moves);
				flim_d  = 6'(lim);
				wl_d    = 6'(lim);
				state_d = (op_q.req_type == rwt_pkg::RT_PIECE) ? rwt_pkg::ST_EMIT1
				                                               : rwt_pkg::ST_RF_RD;
			end

			rwt_pkg::ST_EMIT1: begin
				if (slot_ok) begin
					emit_v = 1'b1;
					emit_e.chunk_index  = op_q.chunk_index;
					emit_e.block_offset = op_q.block_offset;
					emit_e.block_length = op_q.block_length;
					case (op_q.req_type)
						rwt_pkg::RT_CANCEL: emit_act = rwt_pkg::ACT_SEND_CANCEL;
						rwt_pkg::RT_REJECT: emit_act = rwt_pkg::ACT_REJECTED;
						default:            emit_act = rwt_pkg::ACT_DOWNLOADED;
					endcase
					state_d = (op_q.req_type == rwt_pkg::RT_PIECE) ? rwt_pkg::ST_RF_RD
					                                               : rwt_pkg::ST_FIN;
				end
			end

			// move queued heads to the sent tail while the window allows
			rwt_pkg::ST_RF_RD: begin
				if ((qc_q != '0) && (sc_q < w_q)) begin
					q_re    = 1'b1;
					q_raddr = qh_q;
					state_d = rwt_pkg::ST_RF_WR;
				end else begin
					state_d = rwt_pkg::ST_FIN;
				end
			end

			rwt_pkg::ST_RF_WR: begin
				if (slot_ok) begin
					emit_v   = 1'b1;
					emit_act = rwt_pkg::ACT_SEND_REQUEST;
					emit_e   = q_rdata;
					s_we     = 1'b1;
					s_waddr  = s_at(sh_q, sc_q);
					s_wdata.e     = q_rdata;
					s_wdata.stamp = tick_q;
					qh_d     = q_at(qh_q, QCW'(1));
					qc_d     = qc_q - QCW'(1);
					sc_d     = sc_q + SCW'(1);
					state_d  = rwt_pkg::ST_RF_RD;
				end
			end

			// resend stale heads, rotating them to the tail
			rwt_pkg::ST_CK_RD: begin
				if (si_q < sc_q) begin
					s_re    = 1'b1;
					s_raddr = sh_q;
					state_d = rwt_pkg::ST_CK_CHK;
				end else begin
					state_d = rwt_pkg::ST_FIN;
				end
			end

			rwt_pkg::ST_CK_CHK: begin
				if (!stale) begin
					state_d = rwt_pkg::ST_FIN;
				end else if (slot_ok) begin
					emit_v   = 1'b1;
					emit_act = rwt_pkg::ACT_SEND_CANCEL;
					emit_e   = s_rdata.e;
					state_d  = rwt_pkg::ST_CK_REQ;
				end
			end

			rwt_pkg::ST_CK_REQ: begin
				if (slot_ok) begin
					emit_v   = 1'b1;
					emit_act = rwt_pkg::ACT_SEND_REQUEST;
					emit_e   = s_rdata.e;
					s_we     = 1'b1;
					s_waddr  = s_at(sh_q, sc_q);
					s_wdata.e     = s_rdata.e;
					s_wdata.stamp = tick_q;
					sh_d     = s_at(sh_q, SCW'(1));
					si_d     = si_q + SCW'(1);
					state_d  = rwt_pkg::ST_CK_RD;
				end
			end

			// drain for choke and cancel all
			rwt_pkg::ST_DR_S_RD: begin
				if (si_q < sc_q) begin
					s_re    = 1'b1;
					s_raddr = s_at(sh_q, si_q);
					state_d = rwt_pkg::ST_DR_S_OUT;
				end else if (op_q.req_type == rwt_pkg::RT_CHOKE) begin
					qi_d    = '0;
					state_d = rwt_pkg::ST_DR_Q_RD;
				end else begin
					sc_d    = '0;
					qc_d    = '0;
					state_d = rwt_pkg::ST_FIN;
				end
			end

			rwt_pkg::ST_DR_S_OUT: begin
				if (slot_ok) begin
					emit_v   = 1'b1;
					emit_act = (op_q.req_type == rwt_pkg::RT_CHOKE) ? rwt_pkg::ACT_REJECTED
					                                                : rwt_pkg::ACT_SEND_CANCEL;
					emit_e   = s_rdata.e;
					si_d     = si_q + SCW'(1);
					state_d  = rwt_pkg::ST_DR_S_RD;
				end
			end

			rwt_pkg::ST_DR_Q_RD: begin
				if (qi_q < qc_q) begin
					q_re    = 1'b1;
					q_raddr = q_at(qh_q, qi_q);
					state_d = rwt_pkg::ST_DR_Q_OUT;
				end else begin
					sc_d    = '0;
					qc_d    = '0;
					state_d = rwt_pkg::ST_FIN;
				end
			end

			rwt_pkg::ST_DR_Q_OUT: begin
				if (slot_ok) begin
					emit_v   = 1'b1;
					emit_act = rwt_pkg::ACT_REJECTED;
					emit_e   = q_rdata;
					qi_d     = qi_q + QCW'(1);
					state_d  = rwt_pkg::ST_DR_Q_RD;
				end
			end

			// emit a none result if nothing came out, then release the last one
			rwt_pkg::ST_FIN: begin
				if (!p_v_q) begin
					emit_v   = 1'b1;
					emit_act = rwt_pkg::ACT_NONE;
				end else if (shift_ok) begin
					fin_move = 1'b1;
					state_d  = rwt_pkg::ST_IDLE;
				end
			end

			default: state_d = rwt_pkg::ST_IDLE;
		endcase
	end

	// stamp final counts as each result enters the pending stage
	always_comb begin
		emit_item                   = '0;
		emit_item.action            = emit_act;
		emit_item.out_chunk_index   = emit_e.chunk_index;
		emit_item.out_block_offset  = emit_e.block_offset;
		emit_item.out_block_length  = emit_e.block_length;
		emit_item.can_add           = (7'(fq_q) < 7'(flim_q));
		emit_item.outstanding_count = 5'(fs_q);
		emit_item.waiting_count     = 6'(fq_q);
		emit_item.dropped           = drop_q;
		fin_item                    = p_q;
		fin_item.last               = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 1'b0;
			tmo_q  <= rwt_pkg::TIMEOUT_RST;
			tick_q <= '0;
			sh_q   <= '0;
			sc_q   <= '0;
			qh_q   <= '0;
			qc_q   <= '0;
			wl_q   <= rwt_pkg::WAIT_LIMIT_RST;
			si_q   <= '0;
			sk_q   <= '0;
			qi_q   <= '0;
			qk_q   <= '0;
			hit_q  <= 1'b0;
			fs_q   <= '0;
			fq_q   <= '0;
			flim_q <= rwt_pkg::WAIT_LIMIT_RST;
			drop_q <= 1'b0;
			w_q    <= '0;
			p_v_q  <= 1'b0;
			o_v_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rwt_pkg::CFG_FAST_EXT: fast_q <= cfg_data[0];
					rwt_pkg::CFG_TIMEOUT:  tmo_q  <= cfg_data;
					default:               tmo_q  <= tmo_q;
				endcase
			end
			tick_q <= tick_d;
			sh_q   <= sh_d;
			sc_q   <= sc_d;
			qh_q   <= qh_d;
			qc_q   <= qc_d;
			wl_q   <= wl_d;
			si_q   <= si_d;
			sk_q   <= sk_d;
			qi_q   <= qi_d;
			qk_q   <= qk_d;
			hit_q  <= hit_d;
			fs_q   <= fs_d;
			fq_q   <= fq_d;
			flim_q <= flim_d;
			drop_q <= drop_d;
			w_q    <= w_d;

			if (emit_v) begin
				p_v_q <= 1'b1;
			end else if (fin_move) begin
				p_v_q <= 1'b0;
			end

			if ((emit_v && p_v_q) || fin_move) begin
				o_v_q <= 1'b1;
			end else if (rsp_ready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	// payload: advance pending into the output register as results arrive
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q <= req;
		end
		if (emit_v) begin
			if (p_v_q) begin
				o_q <= p_q;
			end
			p_q <= emit_item;
		end else if (fin_move) begin
			o_q <= fin_item;
		end
	end

endmodule

[rtl/rwt_check.sv]
// Port-level checker for the request window tracker, bound to the top level.
// Depends on rwt_pkg and request_window_tracker_defines.svh.
`include "request_window_tracker_defines.svh"

module rwt_check (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input rwt_pkg::out_item_t rsp
);

	// one command at a time: ready drops after each transfer
	`RWT_ASSERT_NEXT(a_one_cmd, req_valid && req_ready, !req_ready)

	// a stalled result holds
	`RWT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// a none result is the whole answer
	`RWT_ASSERT_NOW(a_none_last, rsp_valid && (rsp.action == rwt_pkg::ACT_NONE), rsp.last)

	// a dropped download only refills
	`RWT_ASSERT_NOW(a_drop_act, rsp_valid && rsp.dropped,
		(rsp.action == rwt_pkg::ACT_SEND_REQUEST) || (rsp.action == rwt_pkg::ACT_NONE))

endmodule

bind request_window_tracker rwt_check u_rwt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

[tb/sv/rwt_scoreboard.sv]
`timescale 1ns / 1ps
// Checker for the request window tracker: watches the command and result channels,
// predicts every result from its own copy of the window state and compares.
// Depends on rwt_pkg.
module rwt_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  rwt_pkg::in_item_t  req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  rwt_pkg::out_item_t rsp,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	import rwt_pkg::*;

	localparam int SDEPTH = 16;
	localparam int QDEPTH = 32;

	out_item_t expected_q[$];
	ent_t      sent_q[$];
	logic [31:0] stamp_q[$];
	ent_t      queued_q[$];
	logic        fast_ext;
	logic [31:0] timeout;
	logic [31:0] clock_now;
	int          limit;

	function automatic out_item_t mk(action_t a, ent_t e);
		out_item_t r;
		r = '0;
		r.action = a;
		r.out_chunk_index = e.chunk_index;
		r.out_block_offset = e.block_offset;
		r.out_block_length = e.block_length;
		return r;
	endfunction

	function automatic bit drop_queued(ent_t e);
		bit hit;
		hit = 0;
		for (int i = queued_q.size() - 1; i >= 0; i--)
			if (queued_q[i] == e) begin
				queued_q.delete(i);
				hit = 1;
			end
		return hit;
	endfunction

	function automatic bit drop_sent(ent_t e);
		bit hit;
		hit = 0;
		for (int i = sent_q.size() - 1; i >= 0; i--)
			if (sent_q[i] == e) begin
				sent_q.delete(i);
				stamp_q.delete(i);
				hit = 1;
			end
		return hit;
	endfunction

	task automatic refill_window(logic [31:0] rate, ref out_item_t res[$]);
		logic [63:0] w;
		int lim;
		ent_t e;
		w = 1 + ((64'd10 * rate + 64'h3fff) >> 14);
		if (w > SDEPTH) w = SDEPTH;
		while (queued_q.size() > 0 && sent_q.size() < w) begin
			e = queued_q[0];
			queued_q.delete(0);
			sent_q.push_back(e);
			stamp_q.push_back(clock_now);
			res.push_back(mk(ACT_SEND_REQUEST, e));
		end
		lim = 2 * int'(w);
		if (lim < 10) lim = 10;
		if (lim > QDEPTH) lim = QDEPTH;
		limit = lim;
	endtask

	task automatic predict_command(in_item_t c);
		out_item_t res[$];
		ent_t e, h;
		bit full;
		int visits;
		full = 0;
		e = '{c.chunk_index, c.block_offset, c.block_length};
		case (c.req_type)
			RT_DOWNLOAD: begin
				if (queued_q.size() >= QDEPTH) full = 1;
				else queued_q.push_back(e);
				refill_window(c.download_rate, res);
			end
			RT_CANCEL:
				if (!drop_queued(e) && drop_sent(e)) res.push_back(mk(ACT_SEND_CANCEL, e));
			RT_REJECT:
				if (drop_sent(e)) res.push_back(mk(ACT_REJECTED, e));
			RT_PIECE: begin
				if (!drop_queued(e)) void'(drop_sent(e));
				res.push_back(mk(ACT_DOWNLOADED, e));
				refill_window(c.download_rate, res);
			end
			RT_CHOKE:
				if (!fast_ext) begin
					foreach (sent_q[i]) res.push_back(mk(ACT_REJECTED, sent_q[i]));
					foreach (queued_q[i]) res.push_back(mk(ACT_REJECTED, queued_q[i]));
					sent_q.delete(); stamp_q.delete(); queued_q.delete();
				end
			RT_TICK: clock_now = clock_now + 1;
			RT_CHECK: begin
				visits = sent_q.size();
				while (visits > 0 && sent_q.size() > 0 &&
						(clock_now - stamp_q[0]) > timeout) begin
					h = sent_q[0];
					sent_q.delete(0);
					stamp_q.delete(0);
					res.push_back(mk(ACT_SEND_CANCEL, h));
					res.push_back(mk(ACT_SEND_REQUEST, h));
					sent_q.push_back(h);
					stamp_q.push_back(clock_now);
					visits--;
				end
			end
			default: begin
				foreach (sent_q[i]) res.push_back(mk(ACT_SEND_CANCEL, sent_q[i]));
				sent_q.delete(); stamp_q.delete(); queued_q.delete();
			end
		endcase
		if (res.size() == 0) res.push_back(mk(ACT_NONE, '0));
		foreach (res[k]) begin
			res[k].last = (k == res.size() - 1);
			res[k].can_add = queued_q.size() < limit;
			res[k].outstanding_count = sent_q.size();
			res[k].waiting_count = queued_q.size();
			res[k].dropped = full;
			expected_q.push_back(res[k]);
		end
	endtask

	task automatic compare_result(out_item_t got);
		out_item_t x;
		if (expected_q.size() == 0) begin
			$error("unexpected result action=%0d", got.action);
			errors++;
			return;
		end
		x = expected_q[0];
		expected_q.delete(0);
		if (got.action !== x.action) begin
			$error("action exp %0d got %0d", x.action, got.action); errors++; end
		if (got.out_chunk_index !== x.out_chunk_index) begin
			$error("out_chunk_index exp %0h got %0h", x.out_chunk_index, got.out_chunk_index);
			errors++; end
		if (got.out_block_offset !== x.out_block_offset) begin
			$error("out_block_offset exp %0h got %0h", x.out_block_offset, got.out_block_offset);
			errors++; end
		if (got.out_block_length !== x.out_block_length) begin
			$error("out_block_length exp %0h got %0h", x.out_block_length, got.out_block_length);
			errors++; end
		if (got.last !== x.last) begin
			$error("last exp %0d got %0d", x.last, got.last); errors++; end
		if (got.can_add !== x.can_add) begin
			$error("can_add exp %0d got %0d", x.can_add, got.can_add); errors++; end
		if (got.outstanding_count !== x.outstanding_count) begin
			$error("outstanding_count exp %0d got %0d", x.outstanding_count,
				got.outstanding_count); errors++; end
		if (got.waiting_count !== x.waiting_count) begin
			$error("waiting_count exp %0d got %0d", x.waiting_count, got.waiting_count);
			errors++; end
		if (got.dropped !== x.dropped) begin
			$error("dropped exp %0d got %0d", x.dropped, got.dropped); errors++; end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			expected_q.delete(); sent_q.delete(); stamp_q.delete(); queued_q.delete();
			fast_ext = 0;
			timeout = TIMEOUT_RST;
			clock_now = 0;
			limit = WAIT_LIMIT_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FAST_EXT) fast_ext = cfg_data[0];
				else timeout = cfg_data;
			end
			if (rsp_valid && rsp_ready) compare_result(rsp);
			if (req_valid && req_ready) predict_command(req);
			pending = expected_q.size();
		end
	end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the request window tracker testbench: clock, reset, stimulus and verdict.
// Depends on rwt_pkg, request_window_tracker and rwt_scoreboard.
module tb;
	import rwt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	in_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	out_item_t rsp;
	logic cfg_we = 0;
	logic [0:0] cfg_index = CFG_FAST_EXT;
	logic [31:0] cfg_data = 0;
	int errors, pending;
	int cycles = 0;
	bit stall_long = 0;

	// Small pool of requests so cancels, rejects and pieces hit stored entries.
	ent_t pool[$];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	request_window_tracker uut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

	rwt_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending));

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random ready gaps, plus one long hold-off on request.
	initial begin
		int gap;
		bit long_done;
		long_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_long && !long_done) begin
				rsp_ready <= 0;
				repeat (300) @(negedge clk);
				long_done = 1;
			end
			gap = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				rsp_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1;
			@(posedge clk);
			while (!(rsp_valid && rsp_ready)) @(posedge clk);
		end
	end

	// Offer one command and hold it until the transfer; valid stays up when
	// the next command follows with no gap.
	task automatic send(req_type_t t, ent_t e, logic [31:0] rate);
		int gap;
		in_item_t it;
		gap = $urandom_range(0, 3);
		it.req_type = t;
		it.chunk_index = e.chunk_index;
		it.block_offset = e.block_offset;
		it.block_length = e.block_length;
		it.download_rate = rate;
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1;
		req <= it;
		@(posedge clk);
		while (!(req_valid && req_ready)) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic quiesce();
		req_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		req_valid <= 0;
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic ent_t pick();
		ent_t e;
		if (pool.size() == 0 || $urandom_range(0, 9) == 0)
			e = '{$urandom, $urandom, $urandom};
		else
			e = pool[$urandom_range(0, pool.size() - 1)];
		return e;
	endfunction

	function automatic logic [31:0] rnd_rate();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 20000);
			1: return $urandom;
			2: return 32'hffffffff;
			default: return $urandom_range(0, 100000);
		endcase
	endfunction

	task automatic random_phase(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 40) send(RT_DOWNLOAD, pick(), rnd_rate());
			else if (r < 50) send(RT_CANCEL, pick(), 0);
			else if (r < 58) send(RT_REJECT, pick(), 0);
			else if (r < 72) send(RT_PIECE, pick(), rnd_rate());
			else if (r < 75) send(RT_CHOKE, pick(), $urandom);
			else if (r < 88) send(RT_TICK, pick(), $urandom);
			else if (r < 97) send(RT_CHECK, pick(), $urandom);
			else send(RT_CANCEL_ALL, pick(), $urandom);
		end
	endtask

	initial begin
		ent_t z, ones;
		repeat (6) @(negedge clk);
		arst_n = 1;
		for (int i = 0; i < 12; i++) pool.push_back('{$urandom_range(0, 7), $urandom, $urandom});
		z = '0;
		ones = '{32'hffffffff, 32'hffffffff, 32'hffffffff};

		// Directed: every command, field extremes, drop on full, timeout resend.
		write_reg(CFG_TIMEOUT, 1);
		send(RT_TICK, z, 0);
		send(RT_CHECK, z, 0);
		send(RT_DOWNLOAD, z, 0);
		send(RT_DOWNLOAD, ones, 32'hffffffff);
		send(RT_CANCEL, ones, 0);
		send(RT_REJECT, z, 0);
		send(RT_CANCEL, ones, 0);
		send(RT_TICK, z, 0);
		send(RT_TICK, z, 0);
		send(RT_DOWNLOAD, pool[0], 0);
		send(RT_CHECK, z, 0);
		send(RT_PIECE, pool[0], 16384);
		send(RT_PIECE, ones, 32'hffffffff);
		for (int i = 0; i < 4; i++) send(RT_DOWNLOAD, pool[i], 0);
		send(RT_CHOKE, z, 0);
		send(RT_CANCEL_ALL, z, 0);
		// Fill the waiting FIFO past depth with rate 0 (window 1) and long-stall.
		stall_long = 1;
		for (int i = 0; i < 36; i++) send(RT_DOWNLOAD, pool[i % 12], 0);
		send(RT_CANCEL_ALL, z, 0);
		quiesce();

		write_reg(CFG_FAST_EXT, 1);
		write_reg(CFG_TIMEOUT, 32'hffffffff);
		random_phase(60);
		quiesce();
		write_reg(CFG_FAST_EXT, 0);
		write_reg(CFG_TIMEOUT, 0);
		random_phase(70);
		quiesce();
		write_reg(CFG_TIMEOUT, 3);
		random_phase(70);
		quiesce();

		if (errors == 0 && pending == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
